// ===== design/decision_tree_leaf_finder_assert.svh =====
// assertion macros for the decision tree leaf finder
`ifndef DECISION_TREE_LEAF_FINDER_ASSERT_SVH
`define DECISION_TREE_LEAF_FINDER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DTLF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DTLF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dtlf_pkg.sv =====
// types and constants for the decision tree leaf finder
package dtlf_pkg;

  localparam int OP_W        = 2;
  localparam int IDX_W       = 10;
  localparam int FEAT_IDX_W  = 6;
  localparam int FIELD_VAL_W = 32;
  localparam int STEP_W      = 11;
  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 24;

  localparam logic [OP_W-1:0] OP_WRITE_NODE    = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_FEATURE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLASSIFY      = 2'd2;

  localparam logic [STEP_W-1:0] STEP_LIMIT_RESET = 11'd1024;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NODE_WAIT,
    ST_FEAT_WAIT,
    ST_FINISH
  } walk_state_t;

endpackage

// ===== design/decision_tree_leaf_finder.sv =====
// decision tree leaf finder: node table, feature store and tree walker
//
// s_axis carries one word per item, its kind in s_axis_tuser: node write,
// feature write or classify. Every input word is taken only while the
// walker is idle. Node and feature writes give no result; unused kind
// codes are dropped. A classify word starts a walk from node 0. Each
// level is one node memory read, then one feature memory read and a
// signed compare. The result word appears on m_axis once the walk
// reaches a leaf or the step limit, with walk_error set at the limit.
// m_axis holds its word in an output register until m_axis_tready is high;
// writes are still accepted while a result waits, and a finished walk
// waits in its last state until the output register is free.
// cfg carries step_limit and is taken only while the walker is idle.
// rst clears the control state and sets step_limit to 1024; the node
// table and feature store keep no reset value and must be written first.
`include "decision_tree_leaf_finder_assert.svh"

module decision_tree_leaf_finder #(
  parameter int NODE_COUNT    = 1024,
  parameter int FEATURE_COUNT = 64,
  parameter int VALUE_WIDTH   = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // node_index, left_child, right_child, split_feature, split_threshold,
  // feature_index, feature_value, zero pad
  input  logic [dtlf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation
  input  logic [dtlf_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // leaf_node, steps_taken, zero pad
  output logic [dtlf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // walk_error
  output logic [0:0]                       m_axis_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dtlf_pkg::STEP_W-1:0]      cfg_data
);

  import dtlf_pkg::*;

  localparam int NW     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int FW     = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int NODE_WORD_W = 2 * IDX_W + FEAT_IDX_W + VALUE_WIDTH;

  function automatic logic [VALUE_WIDTH-1:0] to_value(input logic [FIELD_VAL_W-1:0] f);
    logic [63:0] ext;
    ext = {{(64 - FIELD_VAL_W){f[FIELD_VAL_W-1]}}, f};
    return ext[VALUE_WIDTH-1:0];
  endfunction

  // input fields
  logic [OP_W-1:0]        in_op;
  logic [IDX_W-1:0]       in_node_index;
  logic [IDX_W-1:0]       in_left;
  logic [IDX_W-1:0]       in_right;
  logic [FEAT_IDX_W-1:0]  in_split_feature;
  logic [FIELD_VAL_W-1:0] in_threshold;
  logic [FEAT_IDX_W-1:0]  in_feature_index;
  logic [FIELD_VAL_W-1:0] in_feature_value;

  assign in_op            = s_axis_tuser;
  assign in_node_index    = s_axis_tdata[9:0];
  assign in_left          = s_axis_tdata[19:10];
  assign in_right         = s_axis_tdata[29:20];
  assign in_split_feature = s_axis_tdata[35:30];
  assign in_threshold     = s_axis_tdata[67:36];
  assign in_feature_index = s_axis_tdata[73:68];
  assign in_feature_value = s_axis_tdata[105:74];

  // memories
  logic [NODE_WORD_W-1:0] node_mem [NODE_COUNT];
  logic [VALUE_WIDTH-1:0] feat_mem [FEATURE_COUNT];
  logic [NODE_WORD_W-1:0] node_rd_q;
  logic [VALUE_WIDTH-1:0] feat_rd_q;

  // control and walk registers
  walk_state_t       state;
  walk_state_t       state_next;
  logic [STEP_W-1:0] step_limit;
  logic [IDX_W-1:0]  node;
  logic [STEP_W-1:0] steps;
  logic              node_oor;
  logic              feat_ok;
  logic              err;
  logic              out_valid;
  logic [IDX_W-1:0]  out_leaf;
  logic [STEP_W-1:0] out_steps;
  logic              out_err;

  // control outputs
  logic              in_accept;
  logic              node_rd_en;
  logic [NW-1:0]     node_rd_addr;
  logic              feat_rd_en;
  logic [FW-1:0]     feat_rd_addr;
  logic              node_wr_en;
  logic              feat_wr_en;
  logic              load_out;
  logic              out_free;

  // datapath
  logic [IDX_W-1:0]                cur_left;
  logic [IDX_W-1:0]                cur_right;
  logic [FEAT_IDX_W-1:0]           cur_sf;
  logic signed [VALUE_WIDTH-1:0]   cur_thr;
  logic signed [VALUE_WIDTH-1:0]   cur_val;
  logic                            at_leaf;
  logic                            at_limit;
  logic [IDX_W-1:0]                next_node;
  logic [16:0]                     next_node_wide;
  logic [16:0]                     wr_node_wide;
  logic [12:0]                     sf_wide;
  logic [12:0]                     wr_feat_wide;

  assign cur_left  = node_rd_q[IDX_W-1:0];
  assign cur_right = node_rd_q[2*IDX_W-1:IDX_W];
  assign cur_sf    = node_rd_q[2*IDX_W+FEAT_IDX_W-1:2*IDX_W];
  assign cur_thr   = node_rd_q[NODE_WORD_W-1:2*IDX_W+FEAT_IDX_W];
  assign cur_val   = feat_ok ? feat_rd_q : '0;
  assign at_leaf   = node_oor || ((cur_left == '0) && (cur_right == '0));
  assign at_limit  = (steps == step_limit);
  assign next_node = (cur_val <= cur_thr) ? cur_left : cur_right;

  assign next_node_wide = {7'd0, next_node};
  assign wr_node_wide   = {7'd0, in_node_index};
  assign sf_wide        = {7'd0, cur_sf};
  assign wr_feat_wide   = {7'd0, in_feature_index};

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid || m_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && (in_op == OP_CLASSIFY)) begin
          state_next = ST_NODE_WAIT;
        end
      end
      ST_NODE_WAIT: begin
        if (at_leaf || at_limit) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_FEAT_WAIT;
        end
      end
      ST_FEAT_WAIT: begin
        state_next = ST_NODE_WAIT;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cfg_ready     = 1'b0;
    node_rd_en    = 1'b0;
    node_rd_addr  = '0;
    feat_rd_en    = 1'b0;
    feat_rd_addr  = sf_wide[FW-1:0];
    node_wr_en    = 1'b0;
    feat_wr_en    = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = !rst;
        cfg_ready     = !rst;
        node_rd_en    = in_accept && (in_op == OP_CLASSIFY);
        node_wr_en    = in_accept && (in_op == OP_WRITE_NODE) &&
                        (32'(in_node_index) < NODE_COUNT);
        feat_wr_en    = in_accept && (in_op == OP_WRITE_FEATURE) &&
                        (32'(in_feature_index) < FEATURE_COUNT);
      end
      ST_NODE_WAIT: begin
        feat_rd_en = !at_leaf && !at_limit && (32'(cur_sf) < FEATURE_COUNT);
      end
      ST_FEAT_WAIT: begin
        node_rd_en   = 32'(next_node) < NODE_COUNT;
        node_rd_addr = next_node_wide[NW-1:0];
      end
      ST_FINISH: begin
        load_out = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // node table and feature store
  always_ff @(posedge clk) begin
    if (node_wr_en) begin
      node_mem[wr_node_wide[NW-1:0]] <= {to_value(in_threshold), in_split_feature,
                                         in_right, in_left};
    end
    if (node_rd_en) begin
      node_rd_q <= node_mem[node_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (feat_wr_en) begin
      feat_mem[wr_feat_wide[FW-1:0]] <= to_value(in_feature_value);
    end
    if (feat_rd_en) begin
      feat_rd_q <= feat_mem[feat_rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step_limit <= STEP_LIMIT_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        step_limit <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        node     <= '0;
        steps    <= '0;
        node_oor <= 1'b0;
        err      <= 1'b0;
      end
      ST_NODE_WAIT: begin
        feat_ok <= 32'(cur_sf) < FEATURE_COUNT;
        err     <= !at_leaf && at_limit;
      end
      ST_FEAT_WAIT: begin
        node     <= next_node;
        steps    <= steps + STEP_W'(1);
        node_oor <= !(32'(next_node) < NODE_COUNT);
      end
      default: begin
        node <= node;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_leaf  <= node;
      out_steps <= steps;
      out_err   <= err;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'd0, out_steps, out_leaf};
  assign m_axis_tuser  = out_err;

  `DTLF_ASSERT_IMP(a_steps_bounded, clk, rst, state == ST_NODE_WAIT, steps <= step_limit, "walk passed the step limit")
  `DTLF_ASSERT_IMP(a_result_from_finish, clk, rst, load_out, state == ST_FINISH && out_free, "result loaded outside the finish state")
  `DTLF_ASSERT_NXT(a_feat_after_node, clk, rst, state == ST_FEAT_WAIT, state == ST_NODE_WAIT, "feature compare not followed by a node read")

endmodule
